>>> src/cp1252_to_utf8_encoder_defines.svh
// Assertion macros for the cp1252 to UTF-8 encoder.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef CP1252_TO_UTF8_ENCODER_DEFINES_SVH
`define CP1252_TO_UTF8_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define C2U_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define C2U_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define C2U_ASSERT_NOW(lbl, ante, cons, msg)
`define C2U_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> src/c2u_pkg.sv
// Shared types and constants for the cp1252 to UTF-8 encoder.
// No dependencies.
package c2u_pkg;

    localparam int unsigned TOTAL_W  = 32;
    localparam int unsigned OUT_DATA_W = 64;

    // UTF-8 sequence lengths
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    localparam logic [15:0] CP_TWO_BYTE_MIN   = 16'h0080;
    localparam logic [15:0] CP_THREE_BYTE_MIN = 16'h0800;

    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [5:0] CONT_MASK  = 6'h3F;

    // C1 control range 0x80..0x9F; undefined slots map to themselves
    localparam logic [15:0] C1_MAP [32] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
        logic [1:0] count;
    } utf8_char_t;

endpackage

>>> src/cp1252_to_utf8_encoder.sv
// Top level of the windows-1252 to UTF-8 encoder: handshakes, running state.
// Depends on c2u_pkg, c2u_encoder and cp1252_to_utf8_encoder_defines.svh.
//
// Usage
//   Slave stream: one windows-1252 byte per beat in s_axis_tdata, with
//   s_axis_tlast marking the last byte of a text. Master stream: one beat
//   per input byte carrying the encoded sequence (one to three bytes plus
//   count), the running byte total for the text, a sticky non-ASCII flag
//   and a flag saying whether total plus a terminator fits out_capacity.
//   cfg_data/cfg_valid writes out_capacity; cfg_ready is always high.
//   Write it only while the block is empty.
// Timing
//   Two-register pipeline: input register, then table lookup, bit packing
//   and the saturating add in one combinational pass, then the result
//   register. Throughput is one byte per cycle while the receiver does
//   not stall, set by the add that carries the running total from one
//   byte to the next.
// Reset and stall
//   Reset empties both registers, clears the running total and flag and
//   sets out_capacity to all ones. When the receiver stalls the result
//   register holds; one more byte may wait in the input register, after
//   which s_axis_tready drops. After a tlast beat the total and flag clear.
`include "cp1252_to_utf8_encoder_defines.svh"

module cp1252_to_utf8_encoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_text

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] utf8_first, [15:8] utf8_second, [23:16] utf8_third,
    // [25:24] utf8_count, [57:26] running_total, [58] non_ascii_seen,
    // [59] still_fits, [63:60] zero
    output logic [c2u_pkg::OUT_DATA_W-1:0] m_axis_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data        // out_capacity
);

    localparam int unsigned TW = c2u_pkg::TOTAL_W;

    // Input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Running state per text
    logic [TW-1:0] total_reg, total_next;
    logic          flag_reg,  flag_next;
    logic [TW-1:0] cap_reg;

    // Result register
    logic                out_vld_reg;
    c2u_pkg::utf8_char_t out_char_reg;
    logic [TW-1:0]       out_total_reg;
    logic                out_flag_reg;
    logic                out_fits_reg;

    c2u_pkg::utf8_char_t enc;
    logic [TW:0]         sum;
    logic                fits;
    logic                advance;

    // Pipeline control: move when the result slot is free or being drained
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign cfg_ready     = 1'b1;

    c2u_encoder u_encoder
    (
        .in_byte (in_byte_reg),
        .utf8    (enc)
    );

    // Saturating running total; fits means total + 1 <= capacity,
    // which for a capacity below 2^32 is simply total < capacity
    always_comb
    begin
        sum = {1'b0, total_reg} + {{(TW-1){1'b0}}, enc.count};
        if (sum[TW])
        begin
            total_next = {TW{1'b1}};
        end
        else
        begin
            total_next = sum[TW-1:0];
        end
        flag_next = flag_reg | in_byte_reg[7];
        fits      = total_next < cap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            total_reg   <= '0;
            flag_reg    <= 1'b0;
            cap_reg     <= {TW{1'b1}};
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
                if (in_last_reg)
                begin
                    total_reg <= '0;
                    flag_reg  <= 1'b0;
                end
                else
                begin
                    total_reg <= total_next;
                    flag_reg  <= flag_next;
                end
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_char_reg  <= enc;
            out_total_reg <= total_next;
            out_flag_reg  <= flag_next;
            out_fits_reg  <= fits;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'h0, out_fits_reg, out_flag_reg, out_total_reg,
                            out_char_reg.count, out_char_reg.third,
                            out_char_reg.second, out_char_reg.first};

    `C2U_ASSERT_NOW(a_no_overwrite, s_axis_tvalid && s_axis_tready && in_vld_reg, advance, "input beat taken over a held byte")
    `C2U_ASSERT_NEXT(a_clear_after_last, advance && in_last_reg, total_reg == '0 && !flag_reg, "running state not cleared after tlast")
    `C2U_ASSERT_NOW(a_single_byte_pad, out_vld_reg && out_char_reg.count == c2u_pkg::LEN_ONE, out_char_reg.second == 8'h00 && out_char_reg.third == 8'h00, "unused UTF-8 bytes not zero")
    `C2U_ASSERT_NOW(a_flag_follows_lead, out_vld_reg && out_char_reg.first[7], out_flag_reg, "multi-byte result without non-ASCII flag")
    `C2U_ASSERT_NOW(a_fits_not_saturated, out_vld_reg && out_fits_reg, out_total_reg != {TW{1'b1}}, "fit reported with saturated total")

endmodule

>>> src/c2u_encoder.sv
// Combinational cp1252 byte to UTF-8 sequence encoder.
// Depends on c2u_pkg (C1 table, utf8_char_t).
module c2u_encoder
(
    input  logic [7:0]          in_byte,
    output c2u_pkg::utf8_char_t utf8
);

    logic [15:0] cp;

    always_comb
    begin
        if (in_byte[7:5] == 3'b100)
        begin
            cp = c2u_pkg::C1_MAP[in_byte[4:0]];
        end
        else
        begin
            cp = {8'h00, in_byte};
        end
    end

    always_comb
    begin
        utf8.first  = 8'h00;
        utf8.second = 8'h00;
        utf8.third  = 8'h00;
        utf8.count  = c2u_pkg::LEN_ONE;
        if (cp < c2u_pkg::CP_TWO_BYTE_MIN)
        begin
            utf8.first = cp[7:0];
        end
        else if (cp < c2u_pkg::CP_THREE_BYTE_MIN)
        begin
            utf8.first  = c2u_pkg::LEAD_TWO | {3'b000, cp[10:6]};
            utf8.second = c2u_pkg::CONT_MARK | {2'b00, cp[5:0] & c2u_pkg::CONT_MASK};
            utf8.count  = c2u_pkg::LEN_TWO;
        end
        else
        begin
            utf8.first  = c2u_pkg::LEAD_THREE | {4'h0, cp[15:12]};
            utf8.second = c2u_pkg::CONT_MARK | {2'b00, cp[11:6]};
            utf8.third  = c2u_pkg::CONT_MARK | {2'b00, cp[5:0] & c2u_pkg::CONT_MASK};
            utf8.count  = c2u_pkg::LEN_THREE;
        end
    end

endmodule
